@@ hdl/mlkem_be_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlkem_be_pkg
// Shared types and constants of the coefficient/byte stream packer.
// ----------------------------------------------------------------------------
package mlkem_be_pkg;

  localparam int BYTE_BITS    = 8;   // bits in one packed byte
  localparam int REDUCE_WIDTH = 12;  // coefficient width that gets reduced mod q
  localparam int VALUE_W      = 12;  // width of value and result_value
  localparam int WIDTH_D_W    = 4;   // width of the width_d register
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;   // two registers at byte addresses 0 and 4

  localparam logic [WIDTH_D_W-1:0] WIDTH_D_RESET = 4'd12;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MODE    = 1'b0,
    REG_WIDTH_D = 1'b1
  } reg_idx_t;

  // Operating mode
  typedef enum logic [0:0] {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

endpackage
`default_nettype wire

@@ hdl/mlkem_byte_encode_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlkem_byte_encode_decode
// Streaming packer between d-bit coefficients and bytes (encode) and
// unpacker from bytes to d-bit coefficients (decode), LSB first.
// ----------------------------------------------------------------------------
// Flow: an accepted item's bits enter the bit buffer, and complete units are
//   then drained from the buffer into the registered result output.
// Throughput: one result per cycle while res_stall is low; an item is accepted
//   in every such cycle while each item completes at most one result. An item
//   that completes several results holds the buffer until all have drained.
// Reset (rst, synchronous): empties the bit buffer and the output register,
//   sets mode to encode and width_d to 12.
module mlkem_byte_encode_decode
  import mlkem_be_pkg::*;
#(
  parameter int MAX_COEFF_BITS = 12,
  parameter int MODULUS        = 3329
) (
  input  wire                      clk,
  input  wire                      rst,
  // APB-style register port
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [APB_ADDR_W-1:0]    paddr,
  input  wire  [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  // item channel
  input  wire                      item_valid,
  output logic                     item_stall,
  input  wire  [VALUE_W-1:0]       value,
  // result channel
  output logic                     res_valid,
  input  wire                      res_stall,
  output logic [VALUE_W-1:0]       result_value,
  output logic                     last_of_run
);

  // Buffer holds fewer than one unit of leftover bits plus one appended item
  localparam int MW    = MAX_COEFF_BITS;
  localparam int BUF_W = MAX_COEFF_BITS + BYTE_BITS - 1;
  localparam int CW    = $clog2(BUF_W + 1);
  localparam int DW    = $clog2(MAX_COEFF_BITS + 1);

  // Configuration registers
  mode_t                mode;
  logic [WIDTH_D_W-1:0] width_d;

  // Bit buffer, oldest bit at bit 0
  logic [BUF_W-1:0] buffer;
  logic [BUF_W-1:0] buffer_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic             res_valid_next;

  logic             cfg_we;
  reg_idx_t         cfg_idx;

  logic [DW-1:0]    d_eff;
  logic [DW-1:0]    unit;
  logic             take;
  logic [BUF_W-1:0] buf_post;
  logic [CW-1:0]    cnt_post;
  logic             room;
  logic             accept;
  logic [BUF_W-1:0] in_bits;
  logic [CW-1:0]    add_bits;
  logic [MW-1:0]    r_raw;
  logic [MW-1:0]    r_red;
  logic             do_reduce;

  // --------------------------------------------------------------------------
  // Register port: zero wait states, write on the access phase.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:    prdata = APB_DATA_W'(mode);
      REG_WIDTH_D: prdata = APB_DATA_W'(width_d);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_ENCODE;
      width_d <= WIDTH_D_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:    mode    <= mode_t'(pwdata[0]);
        REG_WIDTH_D: width_d <= pwdata[WIDTH_D_W-1:0];
        default:     mode    <= mode;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective width: zero counts as one, anything above the maximum clamps.
  // --------------------------------------------------------------------------
  always_comb begin
    if (width_d == '0) begin
      d_eff = DW'(1);
    end else if (32'(width_d) > MAX_COEFF_BITS) begin
      d_eff = DW'(MAX_COEFF_BITS);
    end else begin
      d_eff = DW'(width_d);
    end
  end

  // Size of one result: a byte when packing, d bits when unpacking
  assign unit = (mode == MODE_DECODE) ? d_eff : DW'(BYTE_BITS);

  // --------------------------------------------------------------------------
  // Drain: move one complete unit from the bottom of the buffer into the
  // output register whenever that register is free or being emptied.
  // --------------------------------------------------------------------------
  assign take     = (CW'(unit) <= count) && (!res_valid || !res_stall);
  assign buf_post = take ? (buffer >> unit) : buffer;
  assign cnt_post = take ? (count - CW'(unit)) : count;

  // Take a new item only once the buffer holds no complete unit, so that
  // all results of one item leave before the next item's bits join them.
  assign room       = cnt_post < CW'(unit);
  assign item_stall = !room;
  assign accept     = item_valid && room;

  // Bits of the new item: a d-bit coefficient or the low byte of value
  always_comb begin
    if (mode == MODE_DECODE) begin
      in_bits  = BUF_W'(value[BYTE_BITS-1:0]);
      add_bits = CW'(BYTE_BITS);
    end else begin
      in_bits  = BUF_W'(value) & ~({BUF_W{1'b1}} << d_eff);
      add_bits = CW'(d_eff);
    end
  end

  // Extracted unit, reduced mod q once for full-width coefficients
  assign r_raw     = buffer[MW-1:0] & ~({MW{1'b1}} << unit);
  assign do_reduce = (mode == MODE_DECODE) && (d_eff == DW'(REDUCE_WIDTH)) &&
                     (r_raw >= MW'(MODULUS));
  assign r_red     = do_reduce ? (r_raw - MW'(MODULUS)) : r_raw;

  always_comb begin
    buffer_next = buf_post;
    count_next  = cnt_post;
    if (cfg_we) begin
      // drop pending bits on any register write
      buffer_next = '0;
      count_next  = '0;
    end else if (accept) begin
      buffer_next = buf_post | (in_bits << cnt_post);
      count_next  = cnt_post + add_bits;
    end
  end

  always_comb begin
    if (take) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer    <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      buffer    <= buffer_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  // Output payload: load on drain, hold while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      result_value <= r_red[VALUE_W-1:0];
      last_of_run  <= room;
    end
  end

`ifndef SYNTHESIS
  // The buffer never holds more bits than it has room for
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= BUF_W)
    else $error("bit count exceeds buffer width");

  // A result that is not the last of its run is followed by another one
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_of_run && !cfg_we |=> res_valid)
    else $error("run ended without a last result");

  // Reset leaves the buffer and the output register empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && (count == '0))
    else $error("reset did not empty the datapath");

  // No item enters while a complete unit still sits in the buffer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |-> cnt_post < CW'(unit))
    else $error("item accepted over a pending result");
`endif

endmodule
`default_nettype wire
